>>> rtl/steq_pkg.sv
// Shared widths, codes and reset values of the sorted timer event queue.
`default_nettype none

package steq_pkg;

  localparam int NOW_W    = 64;
  localparam int DELAY_W  = 16;
  localparam int TAG_W    = 16;
  localparam int TPS_W    = 32;
  localparam int STATUS_W = 2;
  localparam int DUR_W    = DELAY_W + TPS_W;

  localparam logic [TPS_W-1:0] TPS_RESET = 32'd19200000;

  // Request kinds.
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_EXPIRE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FIRED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

>>> rtl/steq_if.sv
// Request, response and configuration channel interfaces of the timer event queue.
`default_nettype none

interface steq_in_if;
  import steq_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [NOW_W-1:0]   now;
  logic [DELAY_W-1:0] delay_seconds;
  logic [TAG_W-1:0]   event_tag;

  modport source (output valid, req_type, now, delay_seconds, event_tag, input ready);
  modport sink   (input valid, req_type, now, delay_seconds, event_tag, output ready);
endinterface

interface steq_out_if;
  import steq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    fired_tag;
  logic                load_compare;
  logic [NOW_W-1:0]    compare_ticks;
  logic                timer_enable;

  modport source (output valid, status, fired_tag, load_compare, compare_ticks, timer_enable,
                  input ready);
  modport sink   (input valid, status, fired_tag, load_compare, compare_ticks, timer_enable,
                  output ready);
endinterface

interface steq_cfg_if;
  import steq_pkg::*;
  logic             valid;
  logic             ready;
  logic [TPS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/steq_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none

module steq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sorted_timer_event_queue.sv
// Top level of the sorted timer event queue: list walker, free-slot pool and result register.
//
// Events live in two RAMs, one holding expiry and tag, one holding the list links; the queue
// is a linked list sorted by expiry with equal expiries kept in arrival order. Free slots are
// kept as a chain through the link RAM plus a count of slots never handed out, so no clearing
// pass is needed after reset. An add scales the delay by the tick rate, forms the expiry,
// takes a slot (a freed one in an extra step), walks the list one event per step, writes
// the entry and links it behind its predecessor unless it is the new head. An expiry
// interrupt pops the head and reads the next head's expiry. Items are handled one at a time;
// a finished response sits in the output register while the next request is accepted.
`default_nettype none

module sorted_timer_event_queue #(
  parameter int SLOTS    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  steq_cfg_if.sink   cfg,
  steq_in_if.sink    req,
  steq_out_if.source rsp
);
  import steq_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int DW = NOW_W + TW;
  localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_ALLOC, S_WALK, S_LINK, S_PREV,
    S_FULL, S_EMPTY, S_EXP_POP, S_EXP_NEXT
  } state_t;

  state_t state;

  logic [TPS_W-1:0]   tps;
  logic [LW-1:0]      head;
  logic [LW-1:0]      free_head;
  logic [LW-1:0]      fill;
  logic [NOW_W-1:0]   now_r;
  logic [DELAY_W-1:0] delay_r;
  logic [TW-1:0]      tag_r;
  logic [DUR_W-1:0]   dur;
  logic [NOW_W-1:0]   exp;
  logic [SW-1:0]      slot;
  logic [LW-1:0]      prev;
  logic [LW-1:0]      cur;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [TAG_W-1:0]    rsp_tag;
  logic                rsp_load;
  logic [NOW_W-1:0]    rsp_ticks;
  logic                rsp_enable;

  logic          d_we;
  logic [SW-1:0] d_waddr;
  logic [DW-1:0] d_wdata;
  logic [SW-1:0] d_raddr;
  logic [DW-1:0] d_rdata;
  logic          l_we;
  logic [SW-1:0] l_waddr;
  logic [LW-1:0] l_wdata;
  logic [SW-1:0] l_raddr;
  logic [LW-1:0] l_rdata;

  logic [NOW_W-1:0] rd_exp;
  logic [TW-1:0]    rd_tag;
  logic             rd_later;
  logic             out_free;
  logic             rsp_fill;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.fired_tag     = rsp_tag;
  assign rsp.load_compare  = rsp_load;
  assign rsp.compare_ticks = rsp_ticks;
  assign rsp.timer_enable  = rsp_enable;

  assign rd_exp   = d_rdata[DW-1:TW];
  assign rd_tag   = d_rdata[TW-1:0];
  assign rd_later = (rd_exp > exp);
  assign out_free = !rsp_valid || rsp.ready;
  // High in the cycle that loads a new response into the output register.
  assign rsp_fill = out_free && ((state == S_LINK && prev == NULL_LINK) || state == S_PREV
                    || state == S_FULL || state == S_EMPTY || state == S_EXP_NEXT);

  steq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  steq_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // RAM addressing. By default both RAMs read the current head.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = slot;
    d_wdata = {exp, tag_r};
    d_raddr = head[SW-1:0];
    l_we    = 1'b0;
    l_waddr = slot;
    l_wdata = cur;
    l_raddr = head[SW-1:0];
    case (state)
      S_SUM: begin
        if (free_head != NULL_LINK) begin
          l_raddr = free_head[SW-1:0];
        end
      end
      S_WALK: begin
        if (!rd_later) begin
          d_raddr = l_rdata[SW-1:0];
          l_raddr = l_rdata[SW-1:0];
        end
      end
      S_LINK: begin
        // The new entry is written once; as the new head, only when the output register is free.
        if (prev != NULL_LINK || out_free) begin
          d_we = 1'b1;
          l_we = 1'b1;
        end
      end
      S_PREV: begin
        l_waddr = prev[SW-1:0];
        l_wdata = LW'(slot);
        l_we    = out_free;
      end
      S_EXP_POP: begin
        // The popped slot goes onto the free chain; fetch the new head's expiry.
        l_we    = 1'b1;
        l_waddr = head[SW-1:0];
        l_wdata = free_head;
        d_raddr = l_rdata[SW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tps       <= TPS_RESET;
      head      <= NULL_LINK;
      free_head <= NULL_LINK;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        tps <= cfg.data;
      end
      if (rsp_valid && rsp.ready && !rsp_fill) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            now_r   <= req.now;
            delay_r <= req.delay_seconds;
            tag_r   <= req.event_tag[TW-1:0];
            if (req.req_type == REQ_ADD) begin
              state <= S_MUL;
            end else if (head == NULL_LINK) begin
              state <= S_EMPTY;
            end else begin
              state <= S_EXP_POP;
            end
          end
        end
        S_MUL: begin
          dur   <= DUR_W'(delay_r) * DUR_W'(tps);
          state <= S_SUM;
        end
        S_SUM: begin
          exp <= now_r + NOW_W'(dur);
          if (free_head == NULL_LINK && fill == NULL_LINK) begin
            state <= S_FULL;
          end else if (free_head != NULL_LINK) begin
            slot  <= free_head[SW-1:0];
            state <= S_ALLOC;
          end else begin
            slot  <= fill[SW-1:0];
            fill  <= fill + LW'(1);
            prev  <= NULL_LINK;
            cur   <= head;
            state <= (head == NULL_LINK) ? S_LINK : S_WALK;
          end
        end
        S_ALLOC: begin
          free_head <= l_rdata;
          prev      <= NULL_LINK;
          cur       <= head;
          state     <= (head == NULL_LINK) ? S_LINK : S_WALK;
        end
        S_WALK: begin
          // Pass every entry that expires no later than the new one.
          if (rd_later) begin
            state <= S_LINK;
          end else begin
            prev <= cur;
            cur  <= l_rdata;
            if (l_rdata == NULL_LINK) begin
              state <= S_LINK;
            end
          end
        end
        S_LINK: begin
          if (prev != NULL_LINK) begin
            state <= S_PREV;
          end else if (out_free) begin
            head       <= LW'(slot);
            rsp_valid  <= 1'b1;
            rsp_status <= ST_ADDED;
            rsp_tag    <= '0;
            rsp_load   <= 1'b1;
            rsp_ticks  <= NOW_W'(dur);
            rsp_enable <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_PREV: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            rsp_status <= ST_ADDED;
            rsp_tag    <= '0;
            rsp_load   <= 1'b0;
            rsp_ticks  <= '0;
            rsp_enable <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_FULL: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            rsp_status <= ST_FULL;
            rsp_tag    <= '0;
            rsp_load   <= 1'b0;
            rsp_ticks  <= '0;
            rsp_enable <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            rsp_status <= ST_EMPTY;
            rsp_tag    <= '0;
            rsp_load   <= 1'b0;
            rsp_ticks  <= '0;
            rsp_enable <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_EXP_POP: begin
          tag_r     <= rd_tag;
          free_head <= head;
          head      <= l_rdata;
          state     <= S_EXP_NEXT;
        end
        S_EXP_NEXT: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            rsp_status <= ST_FIRED;
            rsp_tag    <= TAG_W'(tag_r);
            if (head == NULL_LINK) begin
              rsp_load   <= 1'b0;
              rsp_ticks  <= '0;
              rsp_enable <= 1'b0;
            end else begin
              rsp_load   <= 1'b1;
              rsp_ticks  <= (rd_exp > now_r) ? (rd_exp - now_r) : '0;
              rsp_enable <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/steq_check.sv
// Port-level checks of the timer event queue responses, bound to the top level.
`default_nettype none

module steq_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [steq_pkg::STATUS_W-1:0] status,
  input wire logic [steq_pkg::TAG_W-1:0]    fired_tag,
  input wire logic                          load_compare,
  input wire logic [steq_pkg::NOW_W-1:0]    compare_ticks,
  input wire logic                          timer_enable
);
  import steq_pkg::*;

  // A response that is not taken stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(fired_tag)
      && $stable(compare_ticks))
    else $error("response changed while stalled");

  a_empty_irq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |->
      !timer_enable && !load_compare && compare_ticks == '0 && fired_tag == '0)
    else $error("empty interrupt left the timer running");

  a_no_load_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !load_compare |-> compare_ticks == '0)
    else $error("compare ticks given without a load");

  a_add_enables: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_ADDED || status == ST_FULL) |-> timer_enable && fired_tag == '0)
    else $error("add response without the timer enabled");

  a_fire_load: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FIRED |-> load_compare == timer_enable)
    else $error("fired event with inconsistent next-head load");

endmodule

bind sorted_timer_event_queue steq_check u_steq_check (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .fired_tag     (rsp.fired_tag),
  .load_compare  (rsp.load_compare),
  .compare_ticks (rsp.compare_ticks),
  .timer_enable  (rsp.timer_enable)
);

`default_nettype wire

>>> sim/sorted_timer_event_queue_checker.sv
// Checker for the timer event queue: predicts each response from the accepted requests and compares.
`default_nettype none

module sorted_timer_event_queue_checker #(
  parameter int SLOTS    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  steq_cfg_if  cfg,
  steq_in_if   req,
  steq_out_if  rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import steq_pkg::*;

  localparam logic [TAG_W-1:0] TAG_KEEP =
    (TAG_BITS >= TAG_W) ? '1 : TAG_W'((64'd1 << TAG_BITS) - 64'd1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    fired_tag;
    logic                load_compare;
    logic [NOW_W-1:0]    compare_ticks;
    logic                timer_enable;
  } timer_result_t;

  // Shadow of the event pool; a link equal to SLOTS marks the end of the list.
  logic [TPS_W-1:0] tick_rate;
  logic [NOW_W-1:0] due_at [SLOTS];
  logic [TAG_W-1:0] tag_of [SLOTS];
  int               link_of [SLOTS];
  logic             in_use [SLOTS];
  int               head;

  timer_result_t response_fifo [$];
  int            error_total = 0;

  function automatic timer_result_t predict_queue_step(input logic kind,
                                                        input logic [NOW_W-1:0] now,
                                                        input logic [DELAY_W-1:0] delay,
                                                        input logic [TAG_W-1:0] tag);
    timer_result_t    r;
    logic [NOW_W-1:0] span;
    logic [NOW_W-1:0] due;
    int               free_slot;
    int               prev;
    int               cur;
    r = '0;
    if (kind == REQ_ADD) begin
      span = NOW_W'(delay) * NOW_W'(tick_rate);
      due  = now + span;
      free_slot = SLOTS;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!in_use[i]) free_slot = i;
      end
      r.timer_enable = 1'b1;
      if (free_slot == SLOTS) begin
        r.status = ST_FULL;
      end else begin
        // Equal expiries stay in arrival order, so walk past every entry that is not later.
        prev = SLOTS;
        cur  = head;
        for (int i = 0; i < SLOTS && cur != SLOTS; i++) begin
          if (due_at[cur] > due) break;
          prev = cur;
          cur  = link_of[cur];
        end
        due_at[free_slot]  = due;
        tag_of[free_slot]  = tag & TAG_KEEP;
        link_of[free_slot] = cur;
        in_use[free_slot]  = 1'b1;
        r.status = ST_ADDED;
        if (prev == SLOTS) begin
          head = free_slot;
          r.load_compare  = 1'b1;
          r.compare_ticks = span;
        end else begin
          link_of[prev] = free_slot;
        end
      end
    end else if (head == SLOTS) begin
      r.status = ST_EMPTY;
    end else begin
      r.status    = ST_FIRED;
      r.fired_tag = tag_of[head];
      in_use[head] = 1'b0;
      head = link_of[head];
      if (head != SLOTS) begin
        r.load_compare  = 1'b1;
        r.compare_ticks = (due_at[head] > now) ? due_at[head] - now : '0;
        r.timer_enable  = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      tick_rate = TPS_RESET;
      head      = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
        due_at[i]  = '0;
        tag_of[i]  = '0;
        link_of[i] = 0;
        in_use[i]  = 1'b0;
      end
      response_fifo.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (response_fifo.size() == 0) begin
          $error("response with no request waiting: status %0d", rsp.status);
          error_total++;
        end else begin
          want = response_fifo.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            error_total++;
          end
          if (rsp.fired_tag !== want.fired_tag) begin
            $error("fired_tag: expected %0h, actual %0h", want.fired_tag, rsp.fired_tag);
            error_total++;
          end
          if (rsp.load_compare !== want.load_compare) begin
            $error("load_compare: expected %0b, actual %0b", want.load_compare,
                   rsp.load_compare);
            error_total++;
          end
          if (rsp.compare_ticks !== want.compare_ticks) begin
            $error("compare_ticks: expected %0d, actual %0d", want.compare_ticks,
                   rsp.compare_ticks);
            error_total++;
          end
          if (rsp.timer_enable !== want.timer_enable) begin
            $error("timer_enable: expected %0b, actual %0b", want.timer_enable,
                   rsp.timer_enable);
            error_total++;
          end
        end
      end
      if (cfg.valid && cfg.ready) tick_rate = cfg.data;
      if (req.valid && req.ready) begin
        response_fifo.push_back(predict_queue_step(req.req_type, req.now, req.delay_seconds,
                                                   req.event_tag));
      end
    end
    mismatches  <= error_total;
    outstanding <= response_fifo.size();
  end

endmodule

`default_nettype wire

>>> sim/sorted_timer_event_queue_test.sv
// Testbench top of the timer event queue: clock, reset, request stimulus and the verdict.
`default_nettype none

module sorted_timer_event_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import steq_pkg::*;

  localparam int    SLOTS         = 16;
  localparam int    PHASE_ITEMS   = 240;
  localparam longint CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  longint cycle_count = 0;

  // Set for the final phase: neither side idles from then on.
  logic calm = 1'b0;

  logic [NOW_W-1:0]   tick_now   = '0;
  logic [DELAY_W-1:0] last_delay = '0;

  steq_cfg_if cfg_if ();
  steq_in_if  req_if ();
  steq_out_if rsp_if ();

  sorted_timer_event_queue #(
    .SLOTS    (SLOTS),
    .TAG_BITS (16)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .req (req_if),
    .rsp (rsp_if)
  );

  sorted_timer_event_queue_checker #(
    .SLOTS    (SLOTS),
    .TAG_BITS (16)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_if),
    .req         (req_if),
    .rsp         (rsp_if),
    .mismatches  (fail_count),
    .outstanding (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Response side: long ready stretches broken by stall bursts.
  initial begin
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic kind, input logic [NOW_W-1:0] now_val,
                              input logic [DELAY_W-1:0] delay, input logic [TAG_W-1:0] tag);
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.now           <= now_val;
    req_if.delay_seconds <= delay;
    req_if.event_tag     <= tag;
    do @(posedge clk); while (!req_if.ready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= rate;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_request(input int add_pct);
    logic               kind;
    logic [DELAY_W-1:0] delay;
    kind = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_EXPIRE;
    // Time mostly runs forward; now and then it jumps anywhere or close to the wrap.
    case ($urandom_range(0, 11))
      0:       tick_now = {$urandom, $urandom};
      1:       tick_now = '1 - NOW_W'($urandom_range(0, 1000000));
      2, 3:    tick_now = tick_now + NOW_W'($urandom_range(0, 3));
      4, 5:    tick_now = tick_now + {24'd0, 8'($urandom), $urandom};
      default: tick_now = tick_now + NOW_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       delay = '0;
      1:       delay = '1;
      2, 3:    delay = last_delay;
      4, 5, 6: delay = DELAY_W'($urandom_range(0, 4));
      default: delay = DELAY_W'($urandom);
    endcase
    last_delay = delay;
    send_request(kind, tick_now, delay, TAG_W'($urandom));
  endtask

  initial begin
    logic [TPS_W-1:0] rate_plan [6];
    int               add_pct;
    rst                  <= 1'b1;
    cfg_if.valid         <= 1'b0;
    cfg_if.data          <= '0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_ADD;
    req_if.now           <= '0;
    req_if.delay_seconds <= '0;
    req_if.event_tag     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset tick rate.
    send_request(REQ_EXPIRE, '0, '0, '0);
    send_request(REQ_ADD, '0, '0, 16'h0000);
    send_request(REQ_ADD, '0, '1, 16'hFFFF);
    send_request(REQ_ADD, '0, '1, 16'h5A5A);
    // The expiry of this one wraps past the top of the counter.
    send_request(REQ_ADD, '1, 16'd1, 16'hA5A5);
    send_request(REQ_EXPIRE, 64'd5, '0, '0);
    // The next head is already due here, so the remaining ticks saturate.
    send_request(REQ_EXPIRE, '1, '0, '0);
    for (int i = 0; i < 16; i++) begin
      send_request(REQ_ADD, 64'd100, DELAY_W'(i), TAG_W'(16'h1000 + i));
    end
    send_request(REQ_EXPIRE, 64'd100, '0, '0);
    send_request(REQ_EXPIRE, '0, '0, '0);

    rate_plan = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom, TPS_W'($urandom_range(2, 50)),
                  TPS_RESET};
    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      if (p == 5) calm = 1'b1;
      write_tick_rate(rate_plan[p]);
      add_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Segments that fill the pool, drain it, or keep it level.
        if (n % 30 == 0) begin
          case ($urandom_range(0, 2))
            0:       add_pct = 80;
            1:       add_pct = 30;
            default: add_pct = 55;
          endcase
        end
        send_random_request(add_pct);
        if (!calm && $urandom_range(0, 59) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
